// ===== design/tbc_pkg.sv =====
package tbc_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_WIDTH     = 32;

  localparam int EW    = COORD_WIDTH + 1;
  localparam int DPW   = 2 * EW + 2;
  localparam int PRW   = 2 * DPW;
  localparam int NUMW  = PRW + 1;
  localparam int DENW  = PRW;
  localparam int QW    = NUMW + WEIGHT_FRAC_BITS;
  localparam int QSW   = QW + 1;
  localparam int UW    = QW + 3;
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + QW + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [DENW-1:0] den;
    logic [NUMW-1:0] mag_v;
    logic            neg_v;
    logic [NUMW-1:0] mag_w;
    logic            neg_w;
    logic            degen;
  } front_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   num;
    logic [QW-1:0]   quo;
    logic [DENW-1:0] den;
    logic            neg;
  } div_t;

  function automatic logic [WEIGHT_WIDTH-1:0] sat_weight(input logic signed [UW-1:0] a);
    logic [UW-WEIGHT_WIDTH:0] top_bits;
    top_bits = a[UW-1:WEIGHT_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat_weight = a[WEIGHT_WIDTH-1:0];
    end else if (a[UW-1]) begin
      sat_weight = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
    end else begin
      sat_weight = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/tbc_front.sv =====
module tbc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tbc_pkg::coord_t     coord_i [12],
  output logic                valid_o,
  output tbc_pkg::front_t     front_o
);

  localparam int EW   = tbc_pkg::EW;
  localparam int DPW  = tbc_pkg::DPW;
  localparam int PRW  = tbc_pkg::PRW;
  localparam int NUMW = tbc_pkg::NUMW;
  localparam int DENW = tbc_pkg::DENW;

  logic [tbc_pkg::FRONT_STAGES-1:0] vld_q;

  logic signed [EW-1:0]  e0_q [3], e1_q [3], e2_q [3];
  logic signed [DPW-1:0] p00_q [3], p01_q [3], p11_q [3], p20_q [3], p21_q [3];
  logic signed [DPW-1:0] d00_q, d01_q, d11_q, d20_q, d21_q;
  logic signed [PRW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  tbc_pkg::front_t       front_d, front_q;

  logic signed [NUMW-1:0] den_s, numv_s, numw_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[tbc_pkg::FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e0_q[i] <= EW'(coord_i[3+i]) - EW'(coord_i[i]);
      e1_q[i] <= EW'(coord_i[6+i]) - EW'(coord_i[i]);
      e2_q[i] <= EW'(coord_i[9+i]) - EW'(coord_i[i]);
    end
    for (int i = 0; i < 3; i++) begin
      p00_q[i] <= DPW'(e0_q[i]) * DPW'(e0_q[i]);
      p01_q[i] <= DPW'(e0_q[i]) * DPW'(e1_q[i]);
      p11_q[i] <= DPW'(e1_q[i]) * DPW'(e1_q[i]);
      p20_q[i] <= DPW'(e2_q[i]) * DPW'(e0_q[i]);
      p21_q[i] <= DPW'(e2_q[i]) * DPW'(e1_q[i]);
    end
    d00_q <= p00_q[0] + p00_q[1] + p00_q[2];
    d01_q <= p01_q[0] + p01_q[1] + p01_q[2];
    d11_q <= p11_q[0] + p11_q[1] + p11_q[2];
    d20_q <= p20_q[0] + p20_q[1] + p20_q[2];
    d21_q <= p21_q[0] + p21_q[1] + p21_q[2];
    m0_q <= PRW'(d00_q) * PRW'(d11_q);
    m1_q <= PRW'(d01_q) * PRW'(d01_q);
    m2_q <= PRW'(d11_q) * PRW'(d20_q);
    m3_q <= PRW'(d01_q) * PRW'(d21_q);
    m4_q <= PRW'(d00_q) * PRW'(d21_q);
    m5_q <= PRW'(d01_q) * PRW'(d20_q);
    front_q <= front_d;
  end

  always_comb begin
    den_s  = NUMW'(m0_q) - NUMW'(m1_q);
    numv_s = NUMW'(m2_q) - NUMW'(m3_q);
    numw_s = NUMW'(m4_q) - NUMW'(m5_q);
    front_d.den   = den_s[DENW-1:0];
    front_d.neg_v = numv_s[NUMW-1];
    front_d.mag_v = numv_s[NUMW-1] ? NUMW'(-numv_s) : NUMW'(numv_s);
    front_d.neg_w = numw_s[NUMW-1];
    front_d.mag_w = numw_s[NUMW-1] ? NUMW'(-numw_s) : NUMW'(numw_s);
    front_d.degen = den_s[NUMW-1] || (den_s == '0);
  end

  assign valid_o = vld_q[tbc_pkg::FRONT_STAGES-1];
  assign front_o = front_q;

endmodule

// ===== design/tbc_div_cell.sv =====
module tbc_div_cell (
  input  logic          clk_i,
  input  tbc_pkg::div_t d_i,
  output tbc_pkg::div_t q_o
);

  localparam int DENW = tbc_pkg::DENW;
  localparam int QW   = tbc_pkg::QW;

  logic [DENW:0]  trial, diff;
  logic           ge;
  tbc_pkg::div_t  cell_d, cell_q;

  always_comb begin
    trial = {d_i.rem, d_i.num[QW-1]};
    diff  = trial - {1'b0, d_i.den};
    ge    = trial >= {1'b0, d_i.den};
    cell_d.rem = ge ? diff[DENW-1:0] : trial[DENW-1:0];
    cell_d.num = {d_i.num[QW-2:0], 1'b0};
    cell_d.quo = {d_i.quo[QW-2:0], ge};
    cell_d.den = d_i.den;
    cell_d.neg = d_i.neg;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

// ===== design/triangle_barycentric_coords_top.sv =====
// Pipeline: an accepted start passes 5 front stages (for edges, dot products and
// cross terms), 89 restoring-division cells and 1 output register before done_o.
// Throughput: one item per cycle; busy_o is never raised and the receiver cannot stall.
// The divider chain advances one quotient bit per cell every cycle.
// Reset: asynchronous, active low; clears the valid pipeline, no result pending.
module triangle_barycentric_coords_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_a_x_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_a_y_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_a_z_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_b_x_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_b_y_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_b_z_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_c_x_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_c_y_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     corner_c_z_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     query_x_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     query_y_i,
  input  logic [tbc_pkg::COORD_WIDTH-1:0]     query_z_i,
  output logic                                done_o,
  output logic [tbc_pkg::WEIGHT_WIDTH-1:0]    weight_u_o,
  output logic [tbc_pkg::WEIGHT_WIDTH-1:0]    weight_v_o,
  output logic [tbc_pkg::WEIGHT_WIDTH-1:0]    weight_w_o,
  output logic                                degenerate_o
);

  localparam int QW   = tbc_pkg::QW;
  localparam int QSW  = tbc_pkg::QSW;
  localparam int UW   = tbc_pkg::UW;
  localparam int FRAC = tbc_pkg::WEIGHT_FRAC_BITS;

  tbc_pkg::coord_t coord [12];
  logic            front_vld;
  tbc_pkg::front_t front;

  tbc_pkg::div_t   chain_v [QW+1];
  tbc_pkg::div_t   chain_w [QW+1];
  logic [QW-1:0]   vld_q;
  logic [QW-1:0]   degen_q;

  logic signed [QSW-1:0] qv, qw;
  logic signed [UW-1:0]  qu;
  logic                  done_q, degen_out_q;
  logic [tbc_pkg::WEIGHT_WIDTH-1:0] u_q, v_q, w_q;

  assign busy_o = 1'b0;

  assign coord[0]  = corner_a_x_i;
  assign coord[1]  = corner_a_y_i;
  assign coord[2]  = corner_a_z_i;
  assign coord[3]  = corner_b_x_i;
  assign coord[4]  = corner_b_y_i;
  assign coord[5]  = corner_b_z_i;
  assign coord[6]  = corner_c_x_i;
  assign coord[7]  = corner_c_y_i;
  assign coord[8]  = corner_c_z_i;
  assign coord[9]  = query_x_i;
  assign coord[10] = query_y_i;
  assign coord[11] = query_z_i;

  tbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .coord_i (coord),
    .valid_o (front_vld),
    .front_o (front)
  );

  always_comb begin
    chain_v[0].rem = '0;
    chain_v[0].num = {front.mag_v, {FRAC{1'b0}}};
    chain_v[0].quo = '0;
    chain_v[0].den = front.den;
    chain_v[0].neg = front.neg_v;
    chain_w[0].rem = '0;
    chain_w[0].num = {front.mag_w, {FRAC{1'b0}}};
    chain_w[0].quo = '0;
    chain_w[0].den = front.den;
    chain_w[0].neg = front.neg_w;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    tbc_div_cell u_cell_v (.clk_i(clk_i), .d_i(chain_v[i]), .q_o(chain_v[i+1]));
    tbc_div_cell u_cell_w (.clk_i(clk_i), .d_i(chain_w[i]), .q_o(chain_w[i+1]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QW-2:0], front_vld};
      done_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q <= {degen_q[QW-2:0], front.degen};
  end

  always_comb begin
    qv = chain_v[QW].neg ? -$signed({1'b0, chain_v[QW].quo}) : $signed({1'b0, chain_v[QW].quo});
    qw = chain_w[QW].neg ? -$signed({1'b0, chain_w[QW].quo}) : $signed({1'b0, chain_w[QW].quo});
    qu = $signed(UW'(1) <<< FRAC) - UW'(qv) - UW'(qw);
  end

  always_ff @(posedge clk_i) begin
    degen_out_q <= degen_q[QW-1];
    if (degen_q[QW-1]) begin
      u_q <= '0;
      v_q <= '0;
      w_q <= '0;
    end else begin
      u_q <= tbc_pkg::sat_weight(qu);
      v_q <= tbc_pkg::sat_weight(UW'(qv));
      w_q <= tbc_pkg::sat_weight(UW'(qw));
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = degen_out_q;
  assign weight_u_o   = u_q;
  assign weight_v_o   = v_q;
  assign weight_w_o   = w_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(tbc_pkg::LATENCY) done_o)
    else $error("result missing after pipeline latency");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> weight_u_o == '0 && weight_v_o == '0 && weight_w_o == '0)
    else $error("degenerate result with nonzero weights");

  a_chain_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld |-> ##(QW + 1) done_o)
    else $error("divider chain lost a transfer");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int DRAIN_CYCLES = tbc_pkg::LATENCY + 5;

  typedef struct {
    tbc_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
  } tri_query_t;

  typedef struct {
    logic [31:0] u, v, w;
    logic        degen;
  } weights_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] corner_a_x_i, corner_a_y_i, corner_a_z_i;
  logic [15:0] corner_b_x_i, corner_b_y_i, corner_b_z_i;
  logic [15:0] corner_c_x_i, corner_c_y_i, corner_c_z_i;
  logic [15:0] query_x_i, query_y_i, query_z_i;
  logic        done_o;
  logic [31:0] weight_u_o, weight_v_o, weight_w_o;
  logic        degenerate_o;

  weights_t pending_weights[$];
  int       mismatches;

  triangle_barycentric_coords_top uut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [31:0] clamp32(input logic signed [127:0] q);
    logic signed [127:0] hi_lim, lo_lim;
    hi_lim = 128'sd2147483647;
    lo_lim = -hi_lim - 128'sd1;
    if (q > hi_lim) return 32'h7fff_ffff;
    if (q < lo_lim) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic weights_t bary_weights(input tri_query_t t);
    longint e0[3], e1[3], e2[3];
    longint d00, d01, d11, d20, d21;
    logic signed [127:0] s00, s01, s11, s20, s21, den, num_v, num_w, qv, qw, qu;
    weights_t r;
    e0[0] = t.bx - t.ax; e0[1] = t.by - t.ay; e0[2] = t.bz - t.az;
    e1[0] = t.cx - t.ax; e1[1] = t.cy - t.ay; e1[2] = t.cz - t.az;
    e2[0] = t.px - t.ax; e2[1] = t.py - t.ay; e2[2] = t.pz - t.az;
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int i = 0; i < 3; i++) begin
      d00 += e0[i] * e0[i];
      d01 += e0[i] * e1[i];
      d11 += e1[i] * e1[i];
      d20 += e2[i] * e0[i];
      d21 += e2[i] * e1[i];
    end
    s00 = d00; s01 = d01; s11 = d11; s20 = d20; s21 = d21;
    den = s00 * s11 - s01 * s01;
    if (den <= 0) begin
      r.u = '0; r.v = '0; r.w = '0; r.degen = 1'b1;
      return r;
    end
    num_v = s11 * s20 - s01 * s21;
    num_w = s00 * s21 - s01 * s20;
    qv = (num_v <<< tbc_pkg::WEIGHT_FRAC_BITS) / den;
    qw = (num_w <<< tbc_pkg::WEIGHT_FRAC_BITS) / den;
    qu = (128'sd1 <<< tbc_pkg::WEIGHT_FRAC_BITS) - qv - qw;
    r.u = clamp32(qu);
    r.v = clamp32(qv);
    r.w = clamp32(qw);
    r.degen = 1'b0;
    return r;
  endfunction

  // record the expected weights for each accepted transfer
  always @(posedge clk_i) begin
    tri_query_t t;
    if (rst_ni && start_i && !busy_o) begin
      t.ax = corner_a_x_i; t.ay = corner_a_y_i; t.az = corner_a_z_i;
      t.bx = corner_b_x_i; t.by = corner_b_y_i; t.bz = corner_b_z_i;
      t.cx = corner_c_x_i; t.cy = corner_c_y_i; t.cz = corner_c_z_i;
      t.px = query_x_i;    t.py = query_y_i;    t.pz = query_z_i;
      pending_weights = {pending_weights, bary_weights(t)};
    end
  end

  always @(posedge clk_i) begin
    weights_t exp_w;
    if (rst_ni && done_o) begin
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_w = pending_weights.pop_front();
        if (exp_w.u !== weight_u_o || exp_w.v !== weight_v_o ||
            exp_w.w !== weight_w_o || exp_w.degen !== degenerate_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp u=%h v=%h w=%h dg=%b, got u=%h v=%h w=%h dg=%b",
                     $realtime, exp_w.u, exp_w.v, exp_w.w, exp_w.degen,
                     weight_u_o, weight_v_o, weight_w_o, degenerate_o);
        end
      end
    end
  end

  task automatic send_query(input tri_query_t t);
    corner_a_x_i <= t.ax; corner_a_y_i <= t.ay; corner_a_z_i <= t.az;
    corner_b_x_i <= t.bx; corner_b_y_i <= t.by; corner_b_z_i <= t.bz;
    corner_c_x_i <= t.cx; corner_c_y_i <= t.cy; corner_c_z_i <= t.cz;
    query_x_i    <= t.px; query_y_i    <= t.py; query_z_i    <= t.pz;
    start_i      <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int n, sel;
    sel = $urandom_range(99);
    if (sel < 55) n = 0;
    else if (sel < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 50);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic tbc_pkg::coord_t rnd_coord(input int span);
    if (span >= 32768) return tbc_pkg::coord_t'($urandom);
    return tbc_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic tri_query_t make_tri(input tbc_pkg::coord_t a[3],
                                          input tbc_pkg::coord_t b[3],
                                          input tbc_pkg::coord_t c[3],
                                          input tbc_pkg::coord_t p[3]);
    tri_query_t t;
    t.ax = a[0]; t.ay = a[1]; t.az = a[2];
    t.bx = b[0]; t.by = b[1]; t.bz = b[2];
    t.cx = c[0]; t.cy = c[1]; t.cz = c[2];
    t.px = p[0]; t.py = p[1]; t.pz = p[2];
    return t;
  endfunction

  task automatic test_degenerate();
    tbc_pkg::coord_t z[3], k[3], m[3], q[3];
    z = '{0, 0, 0}; k = '{100, 200, -300}; m = '{200, 400, -600}; q = '{5, 6, 7};
    send_query(make_tri(z, z, z, z)); idle_gap();
    send_query(make_tri(k, k, k, q)); idle_gap();
    send_query(make_tri(z, k, m, q)); idle_gap();
    send_query(make_tri(k, k, m, q)); idle_gap();
  endtask

  task automatic test_extremes();
    tbc_pkg::coord_t mn[3], mx[3], a[3], b[3], c[3];
    mn = '{-32768, -32768, -32768}; mx = '{32767, 32767, 32767};
    a = '{-32768, 32767, 0}; b = '{32767, -32768, -32768}; c = '{0, 32767, 32767};
    send_query(make_tri(mn, mx, a, b)); idle_gap();
    send_query(make_tri(a, b, c, mx)); idle_gap();
    send_query(make_tri(a, b, c, mn)); idle_gap();
    send_query(make_tri(mx, a, b, c)); idle_gap();
    send_query(make_tri(mn, c, a, mx)); idle_gap();
    // nearly collinear, far query: saturates
    a = '{0, 0, 0}; b = '{1, 0, 0}; c = '{32767, 1, 0};
    send_query(make_tri(a, b, c, mx)); idle_gap();
    send_query(make_tri(a, b, c, mn)); idle_gap();
  endtask

  task automatic test_unit_triangle();
    tbc_pkg::coord_t a[3], b[3], c[3], p[3];
    a = '{0, 0, 0}; b = '{256, 0, 0}; c = '{0, 256, 0};
    send_query(make_tri(a, b, c, a)); idle_gap();
    send_query(make_tri(a, b, c, b)); idle_gap();
    send_query(make_tri(a, b, c, c)); idle_gap();
    p = '{85, 85, 0};
    send_query(make_tri(a, b, c, p)); idle_gap();
    p = '{-1000, 3000, 77};
    send_query(make_tri(a, b, c, p)); idle_gap();
    a = '{-7, 3, 11}; b = '{3, -5, 2}; c = '{9, 9, -4}; p = '{1, 2, 3};
    send_query(make_tri(a, b, c, p)); idle_gap();
  endtask

  task automatic test_random(input int count);
    tri_query_t t;
    int sel, span;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      span = (sel < 40) ? 32768 : (sel < 70) ? 1000 : (sel < 90) ? 20 : 2;
      t.ax = rnd_coord(span); t.ay = rnd_coord(span); t.az = rnd_coord(span);
      t.bx = rnd_coord(span); t.by = rnd_coord(span); t.bz = rnd_coord(span);
      t.cx = rnd_coord(span); t.cy = rnd_coord(span); t.cz = rnd_coord(span);
      t.px = rnd_coord(32768); t.py = rnd_coord(span); t.pz = rnd_coord(span);
      if (sel % 7 == 0) begin
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end else if (sel % 11 == 0) begin
        t.px = t.ax + ((t.bx - t.ax) >>> 1);
        t.py = t.ay + ((t.by - t.ay) >>> 1);
        t.pz = t.az + ((t.bz - t.az) >>> 1);
      end
      send_query(t);
      idle_gap();
    end
  endtask

  initial begin
    mismatches   = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    corner_a_x_i = '0; corner_a_y_i = '0; corner_a_z_i = '0;
    corner_b_x_i = '0; corner_b_y_i = '0; corner_b_z_i = '0;
    corner_c_x_i = '0; corner_c_y_i = '0; corner_c_z_i = '0;
    query_x_i    = '0; query_y_i    = '0; query_z_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_degenerate();
    test_extremes();
    test_unit_triangle();
    test_random(1330);
    start_i <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
